[src/smab_pkg.sv]
package smab_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 10;
    localparam int LED_W    = 4;
    localparam int CFG_A_W  = 2;

    localparam logic [CFG_A_W-1:0] CFG_LEVEL_HIGH = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_LEVEL_MID  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_LEVEL_LOW  = 2'd2;

    localparam logic [DATA_W-1:0] LEVEL_HIGH_RST = 10'd1023;
    localparam logic [DATA_W-1:0] LEVEL_MID_RST  = 10'd682;
    localparam logic [DATA_W-1:0] LEVEL_LOW_RST  = 10'd341;

    typedef struct packed {
        logic              rejected;
        logic [DATA_W-1:0] held;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] high;
        logic [DATA_W-1:0] mid;
        logic [DATA_W-1:0] low;
    } t_levels;

endpackage

[src/smab_front.sv]
module smab_front
    import smab_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_read_error,
    input  logic                i_q_ready,
    output logic                o_push,
    output t_item               o_item
);

    logic [DATA_W-1:0] r_held;
    logic              w_reject;

    // out of range when any bit above the 10-bit range is set
    assign w_reject = i_read_error || (i_sample[SAMPLE_W-1:DATA_W] != '0);
    assign o_push   = i_valid && i_q_ready;

    assign o_item.rejected = w_reject;
    assign o_item.held     = w_reject ? r_held : i_sample[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (o_push && !w_reject) begin
            r_held <= i_sample[DATA_W-1:0];
        end
    end

endmodule

[src/smab_queue.sv]
module smab_queue
    import smab_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/smab_back.sv]
module smab_back
    import smab_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_item,
    output logic              o_pop,
    input  t_levels           i_levels,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_average,
    output logic [LED_W-1:0]  o_led_pattern,
    output logic              o_rejected
);

    localparam int SUM_W  = $clog2(WINDOW * 1023 + 1);
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int RECIP  = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RCP_W  = $clog2(RECIP + 1);
    localparam int PROD_W = SUM_W + RCP_W;

    localparam logic [RCP_W-1:0] RECIP_V = RCP_W'(RECIP);

    logic [DATA_W-1:0] r_ring [WINDOW];
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic              r_v1;
    logic              r_rej1;
    logic              r_v2;
    logic              r_rej2;
    logic [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0] w_avg;
    logic              w_en;

    assign w_en  = !o_valid || i_ready;
    assign o_pop = w_en && i_q_valid;

    // oldest entry leaves, the held value enters
    assign n_sum = r_sum + SUM_W'(i_item.held) - SUM_W'(r_ring[WINDOW-1]);

    // reciprocal multiply, exact for every sum in range
    assign w_avg = r_prod[SHIFT +: DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else if (o_pop) begin
            r_sum     <= n_sum;
            r_ring[0] <= i_item.held;
            for (int i = 1; i < WINDOW; i++) begin
                r_ring[i] <= r_ring[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r_v1    <= o_pop;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rej1        <= i_item.rejected;
            r_rej2        <= r_rej1;
            r_prod        <= PROD_W'(r_sum) * PROD_W'(RECIP_V);
            o_rejected    <= r_rej2;
            o_average     <= w_avg;
            o_led_pattern <= {w_avg < i_levels.low, w_avg < i_levels.mid,
                              w_avg < i_levels.high, 1'b1};
        end
    end

endmodule

[src/sensor_moving_average_bargraph.sv]
// an input word passes the queue, ring and sum, product and output registers;
// throughput: one word per cycle while the output is not stalled, set by the
// ring update and the pipelined reciprocal multiply that forms the average
// reset (synchronous, active low) clears the held value, ring and sum to zero
// and loads the level registers with 1023, 682 and 341
module sensor_moving_average_bargraph
    import smab_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [SAMPLE_W-1:0] i_s_axis_tdata,  // sample
    input  logic                i_s_axis_tuser,  // read_error
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [15:0]         o_m_axis_tdata,  // average, led_pattern, zero fill
    output logic                o_m_axis_tuser,  // rejected
    input  logic                i_cfg_we,
    input  logic [CFG_A_W-1:0]  i_cfg_addr,
    input  logic [DATA_W-1:0]   i_cfg_wdata
);

    t_levels           r_levels;
    t_item             w_push_item;
    t_item             w_q_item;
    logic              w_push;
    logic              w_pop;
    logic              w_q_valid;
    logic [DATA_W-1:0] w_average;
    logic [LED_W-1:0]  w_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels.high <= LEVEL_HIGH_RST;
            r_levels.mid  <= LEVEL_MID_RST;
            r_levels.low  <= LEVEL_LOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LEVEL_HIGH: r_levels.high <= i_cfg_wdata;
                CFG_LEVEL_MID:  r_levels.mid  <= i_cfg_wdata;
                CFG_LEVEL_LOW:  r_levels.low  <= i_cfg_wdata;
                default:        r_levels      <= r_levels;
            endcase
        end
    end

    smab_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_sample     (i_s_axis_tdata),
        .i_read_error (i_s_axis_tuser),
        .i_q_ready    (o_s_axis_tready),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    smab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_ready (o_s_axis_tready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    smab_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .i_levels      (r_levels),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_average     (w_average),
        .o_led_pattern (w_led),
        .o_rejected    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {2'b00, w_led, w_average};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !w_pop)
        else $error("queue popped while output stalled");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

    a_busy_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> w_q_valid)
        else $error("input stalled with empty queue");

    a_led0_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[DATA_W])
        else $error("led0 dark on a result");

endmodule

[sim/tb_sensor_moving_average_bargraph.sv]
module tb_sensor_moving_average_bargraph;
    import smab_pkg::*;

    localparam int WIN          = 10;
    localparam int PIPE_LAT     = 3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SAMPLE_MAX   = 2**DATA_W - 1;
    localparam int FILL_LSB     = DATA_W + LED_W;
    localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [DATA_W-1:0] avg;
        logic [LED_W-1:0]  leds;
        logic              rej;
    } t_bar_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [SAMPLE_W-1:0] i_s_axis_tdata = '0;   // sample
    logic                i_s_axis_tuser = 1'b0; // read_error
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [15:0]         o_m_axis_tdata;        // average, led_pattern, zero fill
    logic                o_m_axis_tuser;        // rejected
    logic                i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  i_cfg_addr = '0;
    logic [DATA_W-1:0]   i_cfg_wdata = '0;

    sensor_moving_average_bargraph #(
        .WINDOW(WIN)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mirror of the averaging state
    t_levels           lvl = '{LEVEL_HIGH_RST, LEVEL_MID_RST, LEVEL_LOW_RST};
    logic [DATA_W-1:0] held_val = '0;
    logic [DATA_W-1:0] ring_mem [WIN];
    int                ring_ptr = 0;
    int unsigned       win_sum = 0;
    t_bar_word         bar_pending [$];

    bit idle_on = 1'b1;
    int sink_hold = 0;
    int words_sent = 0;
    int rejects_sent = 0;
    int words_checked = 0;
    int mismatches = 0;
    int level_writes = 0;
    int cycle_cnt = 0;

    initial begin
        foreach (ring_mem[k]) ring_mem[k] = '0;
    end

    task automatic advance_average(input logic [SAMPLE_W-1:0] s, input logic err);
        t_bar_word   w;
        int unsigned mean;
        logic        rej;
        rej = err || (s > SAMPLE_MAX);
        if (!rej) held_val = s[DATA_W-1:0];
        win_sum = win_sum - ring_mem[ring_ptr] + held_val;
        ring_mem[ring_ptr] = held_val;
        ring_ptr = (ring_ptr + 1 == WIN) ? 0 : ring_ptr + 1;
        mean = win_sum / WIN;
        w.avg = mean[DATA_W-1:0];
        w.leds = {w.avg < lvl.low, w.avg < lvl.mid, w.avg < lvl.high, 1'b1};
        w.rej = rej;
        if (rej) rejects_sent++;
        bar_pending.push_back(w);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // result side
    always @(posedge i_clk) begin
        t_bar_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (bar_pending.size() == 0) begin
                note_mismatch("unexpected word, average", -1,
                              int'(o_m_axis_tdata[DATA_W-1:0]));
            end else begin
                want = bar_pending.pop_front();
                words_checked++;
                if (o_m_axis_tdata[DATA_W-1:0] !== want.avg)
                    note_mismatch("average", int'(want.avg),
                                  int'(o_m_axis_tdata[DATA_W-1:0]));
                if (o_m_axis_tdata[FILL_LSB-1:DATA_W] !== want.leds)
                    note_mismatch("led_pattern", int'(want.leds),
                                  int'(o_m_axis_tdata[FILL_LSB-1:DATA_W]));
                if (o_m_axis_tuser !== want.rej)
                    note_mismatch("rejected", int'(want.rej), int'(o_m_axis_tuser));
                if (o_m_axis_tdata[15:FILL_LSB] !== '0)
                    note_mismatch("zero fill", 0, int'(o_m_axis_tdata[15:FILL_LSB]));
            end
        end
    end

    // sink stalls
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 17);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic err);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= s;
        i_s_axis_tuser <= err;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        advance_average(s, err);
        words_sent++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (bar_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // block must be idle; the unused index gets a stray value that must be ignored
    task automatic program_levels(input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] md,
                                  input logic [DATA_W-1:0] lo);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_LEVEL_HIGH;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        lvl.high = hi;
        i_cfg_addr <= CFG_LEVEL_MID;
        i_cfg_wdata <= md;
        @(posedge i_clk);
        lvl.mid = md;
        i_cfg_addr <= CFG_LEVEL_LOW;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        lvl.low = lo;
        i_cfg_addr <= CFG_UNUSED;
        i_cfg_wdata <= DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        level_writes += 4;
    endtask

    // runs near thresholds, rails or a random level, noise and free random words
    task automatic stream_mixed(input int n);
        int sent;
        int run;
        int t;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 5))
                    0: t = int'(lvl.high);
                    1: t = int'(lvl.mid);
                    2: t = int'(lvl.low);
                    3: t = 0;
                    4: t = SAMPLE_MAX;
                    default: t = $urandom_range(0, SAMPLE_MAX);
                endcase
                t = t + int'($urandom_range(0, 2)) - 1;
                if (t < 0) t = 0;
                if (t > SAMPLE_MAX) t = SAMPLE_MAX;
                run = $urandom_range(1, 16);
                for (int k = 0; k < run && sent < n; k++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        if ($urandom_range(0, 1) == 0)
                            send_word(SAMPLE_W'($urandom_range(SAMPLE_MAX + 1, 65535)), 1'b0);
                        else
                            send_word(SAMPLE_W'($urandom), 1'b1);
                    end else begin
                        send_word(SAMPLE_W'(t), 1'b0);
                    end
                    sent++;
                end
            end else begin
                if ($urandom_range(0, 3) == 0)
                    send_word(SAMPLE_W'($urandom), $urandom_range(0, 7) == 0);
                else
                    send_word(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                              $urandom_range(0, 7) == 0);
                sent++;
            end
        end
    endtask

    task automatic test_directed_edges();
        logic [SAMPLE_W-1:0] pts [14] = '{
            16'd0, 16'd1023, 16'd1024, 16'hFFFF, 16'd500, 16'hFFFF, 16'd0,
            16'd512, 16'd341, 16'd340, 16'd682, 16'd681, 16'h5555, 16'hAAAA};
        logic errs [14] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        foreach (pts[k]) send_word(pts[k], errs[k]);
        repeat (WIN) send_word(16'd1023, 1'b0);
        drain_results();
    endtask

    task automatic test_level_settings();
        program_levels(10'd0, 10'd0, 10'd0);
        stream_mixed(35);
        drain_results();
        program_levels(10'd1023, 10'd1023, 10'd1023);
        stream_mixed(35);
        drain_results();
        program_levels(10'd100, 10'd500, 10'd900);
        stream_mixed(35);
        drain_results();
        repeat (2) begin
            program_levels(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
            stream_mixed(35);
            drain_results();
        end
        program_levels(LEVEL_HIGH_RST, LEVEL_MID_RST, LEVEL_LOW_RST);
        stream_mixed(35);
        drain_results();
    endtask

    task automatic test_random_stream();
        stream_mixed(200);
        drain_results();
        idle_on = 1'b0;
        stream_mixed(80);
        idle_on = 1'b1;
        stream_mixed(200);
        drain_results();
        program_levels(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        stream_mixed(100);
        drain_results();
    endtask

    task automatic test_steady_tail();
        idle_on = 1'b0;
        stream_mixed(100);
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_level_settings();
        test_random_stream();
        test_steady_tail();
        $display("sent %0d sample words (%0d rejected) under stalls on both sides",
                 words_sent, rejects_sent);
        $display("checked %0d result words across %0d level register writes",
                 words_checked, level_writes);
        if (mismatches == 0 && bar_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, bar_pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
src/smab_pkg.sv
src/smab_front.sv
src/smab_queue.sv
src/smab_back.sv
src/sensor_moving_average_bargraph.sv
sim/tb_sensor_moving_average_bargraph.sv
